@@ rtl/pps_pkg.sv @@
// Shared types and constants for the preemptive priority scheduler.
package pps_pkg;

  localparam int unsigned PRIO_W = 8;
  localparam int unsigned ARR_W  = 16;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned SLOT_W = 4;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remain;
  } slot_rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_TAT,
    ST_EMIT
  } sched_state_e;

endpackage

@@ rtl/pps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/preemptive_priority_scheduler.sv @@
// Load item: no result. Tick item: its result comes after a scan of all MAX_PROCS slots
// (one slot compared per cycle through a single RAM read port and one comparator),
// then update, turnaround and output steps; the next item is taken right after.
// A finished result waits in an output register; a further tick stalls only
// when that register is still full at its end.
// Reset (async, active low) clears loaded and done bits, time, count and handshakes.
module preemptive_priority_scheduler #(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [3:0]  slot_i,
  input  logic [7:0]  prio_level_i,
  input  logic [15:0] arrive_time_i,
  input  logic [15:0] burst_len_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        idle_o,
  output logic [3:0]  run_slot_o,
  output logic        finished_o,
  output logic [31:0] completion_time_o,
  output logic [31:0] turnaround_o,
  output logic [31:0] waiting_o,
  output logic        all_done_o
);

  localparam int unsigned SW = $clog2(MAX_PROCS);
  localparam int unsigned CW = $clog2(MAX_PROCS + 1);
  localparam int unsigned RW = $bits(pps_pkg::slot_rec_t);

  pps_pkg::sched_state_e state_q, state_d;

  logic [MAX_PROCS-1:0] loaded_q, loaded_d;
  logic [MAX_PROCS-1:0] done_q, done_d;
  logic [CW-1:0] active_q, active_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [pps_pkg::TIME_W-1:0] now_q, now_d;

  logic          pipe_ok_q, pipe_ok_d;
  logic [SW-1:0] pipe_idx_q, pipe_idx_d;

  logic               best_vld_q, best_vld_d;
  logic [SW-1:0]      best_idx_q, best_idx_d;
  pps_pkg::slot_rec_t best_rec_q, best_rec_d;
  logic               fin_q, fin_d;
  logic [pps_pkg::TIME_W-1:0] tat_q, tat_d;

  logic        out_vld_q, out_vld_d;
  logic        idle_q, idle_d;
  logic [3:0]  run_q, run_d;
  logic        fin_out_q, fin_out_d;
  logic [31:0] comp_q, comp_d;
  logic [31:0] tat_out_q, tat_out_d;
  logic [31:0] wt_q, wt_d;
  logic        all_q, all_d;

  logic               ram_we, ram_re;
  logic [SW-1:0]      ram_waddr, ram_raddr;
  pps_pkg::slot_rec_t ram_wdata, ram_rdata;

  logic          in_fire;
  logic          slot_ok;
  logic [SW-1:0] load_idx;
  logic          old_act, new_act;
  logic          eligible, better;
  logic [pps_pkg::BURST_W-1:0] rem_dec;

  pps_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_PROCS)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == pps_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_ok    = (32'(slot_i) < MAX_PROCS);
  assign load_idx   = SW'(slot_i);
  assign old_act    = loaded_q[load_idx] && !done_q[load_idx];
  assign new_act    = (burst_len_i != '0);

  // Shared compare unit: one candidate against the running best.
  assign eligible = pipe_ok_q && (32'(ram_rdata.arrival) <= now_q);
  assign better   = !best_vld_q
                 || (ram_rdata.prio > best_rec_q.prio)
                 || ((ram_rdata.prio == best_rec_q.prio)
                     && (ram_rdata.remain < best_rec_q.remain));
  assign rem_dec  = best_rec_q.remain - 16'd1;

  always_comb begin
    state_d    = state_q;
    loaded_d   = loaded_q;
    done_d     = done_q;
    active_d   = active_q;
    cnt_d      = cnt_q;
    now_d      = now_q;
    pipe_ok_d  = 1'b0;
    pipe_idx_d = pipe_idx_q;
    best_vld_d = best_vld_q;
    best_idx_d = best_idx_q;
    best_rec_d = best_rec_q;
    fin_d      = fin_q;
    tat_d      = tat_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    idle_d     = idle_q;
    run_d      = run_q;
    fin_out_d  = fin_out_q;
    comp_d     = comp_q;
    tat_out_d  = tat_out_q;
    wt_d       = wt_q;
    all_d      = all_q;
    ram_we     = 1'b0;
    ram_waddr  = load_idx;
    ram_wdata  = '{prio: prio_level_i, arrival: arrive_time_i,
                   burst: burst_len_i, remain: burst_len_i};
    ram_re     = 1'b0;
    ram_raddr  = cnt_q[SW-1:0];

    unique case (state_q)
      pps_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (req_type_i == pps_pkg::REQ_LOAD) begin
            if (slot_ok) begin
              ram_we             = 1'b1;
              loaded_d[load_idx] = 1'b1;
              done_d[load_idx]   = !new_act;
              active_d           = active_q - CW'(old_act) + CW'(new_act);
            end
          end else begin
            cnt_d      = '0;
            best_vld_d = 1'b0;
            state_d    = pps_pkg::ST_SCAN;
          end
        end
      end
      pps_pkg::ST_SCAN: begin
        // Issue one read per cycle; compare the entry read the cycle before.
        if (cnt_q != CW'(MAX_PROCS)) begin
          ram_re     = 1'b1;
          pipe_ok_d  = loaded_q[cnt_q[SW-1:0]] && !done_q[cnt_q[SW-1:0]];
          pipe_idx_d = cnt_q[SW-1:0];
          cnt_d      = cnt_q + CW'(1);
        end else begin
          state_d = pps_pkg::ST_UPDATE;
        end
        if (eligible && better) begin
          best_vld_d = 1'b1;
          best_idx_d = pipe_idx_q;
          best_rec_d = ram_rdata;
        end
      end
      pps_pkg::ST_UPDATE: begin
        now_d = now_q + 32'd1;
        fin_d = 1'b0;
        if (best_vld_q) begin
          ram_we           = 1'b1;
          ram_waddr        = best_idx_q;
          ram_wdata        = best_rec_q;
          ram_wdata.remain = rem_dec;
          if (rem_dec == '0) begin
            fin_d              = 1'b1;
            done_d[best_idx_q] = 1'b1;
            active_d           = active_q - CW'(1);
          end
        end
        state_d = pps_pkg::ST_TAT;
      end
      pps_pkg::ST_TAT: begin
        tat_d   = now_q - 32'(best_rec_q.arrival);
        state_d = pps_pkg::ST_EMIT;
      end
      pps_pkg::ST_EMIT: begin
        // Hold until the output register is free.
        if (!out_vld_q || out_ready_i) begin
          out_vld_d = 1'b1;
          idle_d    = !best_vld_q;
          run_d     = best_vld_q ? 4'(best_idx_q) : 4'd0;
          fin_out_d = fin_q;
          comp_d    = fin_q ? now_q : 32'd0;
          tat_out_d = fin_q ? tat_q : 32'd0;
          wt_d      = fin_q ? (tat_q - 32'(best_rec_q.burst)) : 32'd0;
          all_d     = (active_q == '0);
          state_d   = pps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pps_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q   <= '0;
      done_q     <= '0;
      active_q   <= '0;
      cnt_q      <= '0;
      now_q      <= '0;
      pipe_ok_q  <= 1'b0;
      best_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      loaded_q   <= loaded_d;
      done_q     <= done_d;
      active_q   <= active_d;
      cnt_q      <= cnt_d;
      now_q      <= now_d;
      pipe_ok_q  <= pipe_ok_d;
      best_vld_q <= best_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_idx_q <= pipe_idx_d;
    best_idx_q <= best_idx_d;
    best_rec_q <= best_rec_d;
    fin_q      <= fin_d;
    tat_q      <= tat_d;
    idle_q     <= idle_d;
    run_q      <= run_d;
    fin_out_q  <= fin_out_d;
    comp_q     <= comp_d;
    tat_out_q  <= tat_out_d;
    wt_q       <= wt_d;
    all_q      <= all_d;
  end

  assign out_valid_o       = out_vld_q;
  assign idle_o            = idle_q;
  assign run_slot_o        = run_q;
  assign finished_o        = fin_out_q;
  assign completion_time_o = comp_q;
  assign turnaround_o      = tat_out_q;
  assign waiting_o         = wt_q;
  assign all_done_o        = all_q;

  a_tick_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (req_type_i == pps_pkg::REQ_TICK)) |=> (state_q == pps_pkg::ST_SCAN))
    else $error("tick did not start a scan");

  a_best_is_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == pps_pkg::ST_UPDATE) && best_vld_q)
      |-> (loaded_q[best_idx_q] && !done_q[best_idx_q]))
    else $error("picked slot is not loaded and unfinished");

  a_time_steps_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pps_pkg::ST_UPDATE) |=> (now_q == ($past(now_q) + 32'd1)))
    else $error("time did not advance by one");

  a_active_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(active_q) <= MAX_PROCS))
    else $error("active count exceeds slot count");

  a_fin_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && fin_out_q) |-> !idle_q)
    else $error("finished result reported as idle");

endmodule

@@ verif/tb_preemptive_priority_scheduler.sv @@
// Self-checking testbench for the preemptive priority scheduler.
`timescale 1ns / 1ps

module tb_preemptive_priority_scheduler;

  localparam int unsigned NSLOTS    = 16;
  localparam int unsigned RAND_REQS = 1950;
  localparam int unsigned LIMIT     = 600000;
  localparam int unsigned DRAIN     = 40;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  slot;
    logic [7:0]  prio;
    logic [15:0] arrival;
    logic [15:0] burst;
  } sched_req_t;

  typedef struct packed {
    logic        idle;
    logic [3:0]  run_slot;
    logic        finished;
    logic [31:0] completion;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic        all_done;
  } tick_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        req_type_i = 1'b0;
  logic [3:0]  slot_i = '0;
  logic [7:0]  prio_level_i = '0;
  logic [15:0] arrive_time_i = '0;
  logic [15:0] burst_len_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        idle_o;
  logic [3:0]  run_slot_o;
  logic        finished_o;
  logic [31:0] completion_time_o;
  logic [31:0] turnaround_o;
  logic [31:0] waiting_o;
  logic        all_done_o;

  preemptive_priority_scheduler #(.MAX_PROCS(NSLOTS)) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .slot_i            (slot_i),
    .prio_level_i      (prio_level_i),
    .arrive_time_i     (arrive_time_i),
    .burst_len_i       (burst_len_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .idle_o            (idle_o),
    .run_slot_o        (run_slot_o),
    .finished_o        (finished_o),
    .completion_time_o (completion_time_o),
    .turnaround_o      (turnaround_o),
    .waiting_o         (waiting_o),
    .all_done_o        (all_done_o)
  );

  always #1 clk_i = ~clk_i;

  // Scheduler shadow state
  logic [7:0]  prio_tbl   [NSLOTS];
  logic [15:0] arr_tbl    [NSLOTS];
  logic [15:0] burst_tbl  [NSLOTS];
  logic [15:0] remain_tbl [NSLOTS];
  logic        loaded_bits [NSLOTS];
  logic        done_bits   [NSLOTS];
  logic [31:0] now_t;

  sched_req_t   req_queue[$];
  tick_report_t tick_reports[$];
  sched_req_t   nxt_req;

  int unsigned total_reqs = 0;
  int unsigned beats_in = 0;
  int unsigned err_count = 0;
  int unsigned cycles = 0;
  int unsigned send_gap;
  int unsigned recv_gap;
  int          est_now = 0;
  logic        in_took = 1'b0;

  always_comb begin
    if (beats_in < total_reqs / 3) begin
      send_gap = 15;
      recv_gap = 48;
    end else if (beats_in < 2 * total_reqs / 3) begin
      send_gap = 48;
      recv_gap = 15;
    end else begin
      send_gap = 0;
      recv_gap = 0;
    end
  end

  task automatic sched_apply(input sched_req_t r);
    int           best;
    tick_report_t rep;
    logic         pending;
    best = -1;
    rep = '0;
    pending = 1'b0;
    if (r.req_type == pps_pkg::REQ_LOAD) begin
      prio_tbl[r.slot]    = r.prio;
      arr_tbl[r.slot]     = r.arrival;
      burst_tbl[r.slot]   = r.burst;
      remain_tbl[r.slot]  = r.burst;
      loaded_bits[r.slot] = 1'b1;
      done_bits[r.slot]   = (r.burst == 16'd0);
    end else begin
      for (int k = 0; k < NSLOTS; k++) begin
        if (loaded_bits[k] && !done_bits[k] && {16'd0, arr_tbl[k]} <= now_t) begin
          if (best < 0 || prio_tbl[k] > prio_tbl[best] ||
              (prio_tbl[k] == prio_tbl[best] && remain_tbl[k] < remain_tbl[best]))
            best = k;
        end
      end
      now_t = now_t + 32'd1;
      if (best >= 0) begin
        rep.run_slot = best[3:0];
        remain_tbl[best] = remain_tbl[best] - 16'd1;
        if (remain_tbl[best] == 16'd0) begin
          done_bits[best] = 1'b1;
          rep.finished    = 1'b1;
          rep.completion  = now_t;
          rep.turnaround  = now_t - {16'd0, arr_tbl[best]};
          rep.waiting     = rep.turnaround - {16'd0, burst_tbl[best]};
        end
      end else begin
        rep.idle = 1'b1;
      end
      for (int k = 0; k < NSLOTS; k++)
        if (loaded_bits[k] && !done_bits[k]) pending = 1'b1;
      rep.all_done = !pending;
      tick_reports.push_back(rep);
    end
  endtask

  task automatic queue_load(input int s, input int p, input int a, input int b);
    sched_req_t r;
    r.req_type = pps_pkg::REQ_LOAD;
    r.slot     = s[3:0];
    r.prio     = p[7:0];
    r.arrival  = a[15:0];
    r.burst    = b[15:0];
    req_queue.push_back(r);
  endtask

  // Tick payload fields are don't-care; fill them with noise.
  task automatic queue_tick();
    sched_req_t r;
    r.req_type = pps_pkg::REQ_TICK;
    r.slot     = 4'($urandom_range(15));
    r.prio     = 8'($urandom_range(255));
    r.arrival  = 16'($urandom_range(65535));
    r.burst    = 16'($urandom_range(65535));
    req_queue.push_back(r);
    est_now++;
  endtask

  // Driver: hold the beat until taken, then maybe idle
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_took) begin
      if (req_queue.size() != 0 && $urandom_range(99) >= send_gap) begin
        nxt_req = req_queue.pop_front();
        in_valid_i    <= 1'b1;
        req_type_i    <= nxt_req.req_type;
        slot_i        <= nxt_req.slot;
        prio_level_i  <= nxt_req.prio;
        arrive_time_i <= nxt_req.arrival;
        burst_len_i   <= nxt_req.burst;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_gap);
  end

  // Monitor: predict on input beats, check output beats
  always @(posedge clk_i) begin
    tick_report_t exp_rep;
    if (!rst_ni) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        if (tick_reports.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("cycle %0d: result with no tick pending", cycles);
        end else begin
          exp_rep = tick_reports.pop_front();
          if (idle_o !== exp_rep.idle || run_slot_o !== exp_rep.run_slot ||
              finished_o !== exp_rep.finished ||
              completion_time_o !== exp_rep.completion ||
              turnaround_o !== exp_rep.turnaround || waiting_o !== exp_rep.waiting ||
              all_done_o !== exp_rep.all_done) begin
            err_count++;
            if (err_count <= 10) begin
              $display("cycle %0d exp: idle=%0b slot=%0d fin=%0b comp=%0d tat=%0d wait=%0d done=%0b",
                       cycles, exp_rep.idle, exp_rep.run_slot, exp_rep.finished,
                       exp_rep.completion, exp_rep.turnaround, exp_rep.waiting,
                       exp_rep.all_done);
              $display("cycle %0d got: idle=%0b slot=%0d fin=%0b comp=%0d tat=%0d wait=%0d done=%0b",
                       cycles, idle_o, run_slot_o, finished_o, completion_time_o,
                       turnaround_o, waiting_o, all_done_o);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        beats_in++;
        sched_apply({req_type_i, slot_i, prio_level_i, arrive_time_i, burst_len_i});
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int r;
    int a;
    for (int k = 0; k < NSLOTS; k++) begin
      loaded_bits[k] = 1'b0;
      done_bits[k]   = 1'b0;
    end
    now_t = '0;

    // Directed: empty table, priority zero, ties, never-ready, zero burst, reload
    queue_tick();
    queue_load(0, 0, 0, 2);
    queue_load(15, 255, 65535, 65535);
    queue_tick();
    queue_load(3, 0, 0, 1);
    queue_tick();
    queue_tick();
    queue_load(5, 7, 10, 1);
    queue_tick();
    queue_load(15, 255, 0, 0);
    queue_load(6, 7, 0, 3);
    queue_load(7, 7, 0, 2);
    queue_tick();
    queue_load(7, 200, 3, 2);
    queue_tick();
    queue_tick();
    for (int i = 0; i < 7; i++) queue_tick();

    // Random: ticks mixed with loads, mostly well-formed loads near current time, some noise
    for (int i = 0; i < RAND_REQS; i++) begin
      r = $urandom_range(99);
      if (r < 35) begin
        a = est_now + $urandom_range(8) - 3;
        if (a < 0) a = 0;
        queue_load($urandom_range(15),
                   ($urandom_range(1) != 0) ? $urandom_range(255) : $urandom_range(3),
                   a, $urandom_range(6, 1));
      end else if (r < 40) begin
        queue_load($urandom_range(15), $urandom_range(255), $urandom_range(65535),
                   $urandom_range(65535));
      end else if (r < 44) begin
        queue_load($urandom_range(15), $urandom_range(255), $urandom_range(65535), 0);
      end else begin
        queue_tick();
      end
    end
    total_reqs = req_queue.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (req_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (tick_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pps_pkg.sv
rtl/pps_ram.sv
rtl/preemptive_priority_scheduler.sv
verif/tb_preemptive_priority_scheduler.sv
